// File: rtl/core/sce_pkg.sv
// Shared types and constants for the color Sobel edge threshold block.
`default_nettype none
package sce_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 65535;

   localparam int PIX_W  = 32;
   localparam int ROW_W  = 16;
   localparam int COL_W  = 12;
   localparam int CSR_W  = 16;
   localparam int CSR_IW = 2;

   typedef enum logic [CSR_IW-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_THRESH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             out_is_edge;
      logic [7:0]       out_alpha;
      logic             out_last_of_run;
   } rsp_type;

   // one 3x3 neighborhood to evaluate: pix[dx][dy], dy is the kernel row
   typedef struct packed {
      logic [2:0][2:0][PIX_W-1:0] pix;
      logic [ROW_W-1:0]           row;
      logic [COL_W-1:0]           col;
      logic                       last;
   } win_job_type;

endpackage
`default_nettype wire

// File: rtl/core/sobel_color_edge_threshold.sv
// Color Sobel edge threshold: row store, 3x3 window, result sequencer, gradient pipe.
// Throughput: one item per cycle while each item gives at most one result and the output
//   is not stalled; more results per item (row end, last row) hold the result sequencer.
// Both row stores share one 64-bit RAM read at accept and written as the item leaves stage 1.
// Reset: synchronous; clears counters, valids and registers (width 1, height 1,
//   threshold 0). Row stores are not cleared and need no clearing pass.
`default_nettype none
module sobel_color_edge_threshold #(
   parameter int MAX_WIDTH  = sce_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sce_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire sce_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output sce_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_wr_en,
   input  wire logic [sce_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [sce_pkg::CSR_W-1:0]    csr_wr_data
);
   import sce_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // configuration
   logic [12:0] width_ff;
   logic [15:0] height_ff;
   logic [7:0]  thresh_ff;
   logic [15:0] thr_sq_ff;
   logic [CW-1:0]    wl;
   logic [ROW_W-1:0] hl;

   // counters
   logic [CW-1:0]    col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             accept, row_end, last_row;

   // stage 1: RAM data returns
   logic             s1_v_ff, s1_go, s1_wr;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_end_ff, s1_last_ff, s1_fwd_ff;
   logic [63:0]      s1_fwd_data_ff, ram_rd, stored;
   logic [PIX_W-1:0] top, mid;
   logic [3:0]       s1_mask;
   logic [2:0][2:0][PIX_W-1:0] win_ff, win_in;

   // stage 2: result sequencer
   logic             s2_v_ff, s2_free, s2_take, issue;
   logic [2:0][2:0][PIX_W-1:0] s2_win_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic [CW-1:0]    s2_col_ff;
   logic [3:0]       pend_ff, pend_in, pick;
   win_job_type      job;
   logic             adv;

   always_comb begin
      if (width_ff == '0) begin
         wl = '0;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         wl = CW'(MAX_WIDTH - 1);
      end else begin
         wl = CW'(width_ff - 13'd1);
      end
      if (height_ff == '0) begin
         hl = '0;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         hl = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hl = height_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 16'd1;
         thresh_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wr_data[12:0];
            CSR_HEIGHT: height_ff <= csr_wr_data;
            CSR_THRESH: thresh_ff <= csr_wr_data[7:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      thr_sq_ff <= 16'(thresh_ff * thresh_ff);
   end

   assign req_stall = s1_v_ff && !s1_go;
   assign accept    = req_valid && !req_stall;
   assign row_end   = col_ff >= wl;
   assign last_row  = row_ff >= hl;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // row stores: [63:32] older row, [31:0] previous row
   sce_ram #(.WIDTH(64), .DEPTH(MAX_WIDTH)) u_rows (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   assign stored = s1_fwd_ff ? s1_fwd_data_ff : ram_rd;
   assign top    = (s1_row_ff == '0) ? s1_pix_ff : stored[63:32];
   assign mid    = (s1_row_ff == '0) ? s1_pix_ff : stored[31:0];

   assign s1_mask[0] = (s1_row_ff != '0) && (s1_col_ff != '0);
   assign s1_mask[1] = (s1_row_ff != '0) && s1_end_ff;
   assign s1_mask[2] = s1_last_ff && (s1_col_ff != '0);
   assign s1_mask[3] = s1_last_ff && s1_end_ff;

   assign s2_free = !s2_v_ff || (adv && pend_in == '0);
   assign s1_go   = s1_v_ff && ((s1_mask == '0) || s2_free);
   assign s1_wr   = s1_go;
   assign s2_take = s1_go && (s1_mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff <= 1'b1;
      end else if (s1_go) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= {req_data.in_alpha, req_data.in_blue,
                            req_data.in_green, req_data.in_red};
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_end_ff      <= row_end;
         s1_last_ff     <= last_row;
         // the RAM read misses a write to the same entry in this very cycle
         s1_fwd_ff      <= s1_wr && (s1_col_ff == col_ff);
         s1_fwd_data_ff <= {mid, s1_pix_ff};
      end
   end

   always_comb begin
      if (s1_col_ff == '0) begin
         for (int j = 0; j < 3; j++) begin
            win_in[j] = {s1_pix_ff, mid, top};
         end
      end else begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = {s1_pix_ff, mid, top};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // sequencer: one result per cycle while the gradient pipe advances, lowest pending first
   assign issue = s2_v_ff && adv;

   always_comb begin
      logic [2:0][2:0][PIX_W-1:0] cols;
      logic                       low;
      pick = '0;
      priority if (pend_ff[0]) pick = 4'b0001;
      else if (pend_ff[1])     pick = 4'b0010;
      else if (pend_ff[2])     pick = 4'b0100;
      else                     pick = 4'b1000;
      pend_in = pend_ff & ~pick;

      // right-edge results replicate the current column
      if (pick[1] || pick[3]) begin
         cols = {s2_win_ff[2], s2_win_ff[2], s2_win_ff[1]};
      end else begin
         cols = s2_win_ff;
      end
      low = pick[2] || pick[3];
      for (int dx = 0; dx < 3; dx++) begin
         if (low) begin
            job.pix[dx][0] = cols[dx][1];
            job.pix[dx][1] = cols[dx][2];
            job.pix[dx][2] = cols[dx][2];
         end else begin
            job.pix[dx] = cols[dx];
         end
      end
      job.row  = low ? s2_row_ff : s2_row_ff - 16'd1;
      job.col  = (pick[0] || pick[2]) ? COL_W'(s2_col_ff - 1'b1) : COL_W'(s2_col_ff);
      job.last = (pend_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         pend_ff <= '0;
      end else if (s2_take) begin
         s2_v_ff <= 1'b1;
         pend_ff <= s1_mask;
      end else if (issue) begin
         s2_v_ff <= (pend_in != '0);
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         s2_win_ff <= win_in;
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
      end
   end

   sce_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .job_valid (s2_v_ff),
      .job       (job),
      .thr_sq    (thr_sq_ff),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_pend : assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> (pend_ff != '0))
      else $error("sequencer busy with nothing pending");
   a_take : assert property (@(posedge clock) disable iff (reset)
      s2_take |-> (!s2_v_ff || (issue && pend_in == '0)))
      else $error("sequencer overwritten with results pending");
   a_s1 : assert property (@(posedge clock) disable iff (reset)
      (accept && s1_v_ff) |-> s1_go)
      else $error("item accepted over a held item");
   a_fwd : assert property (@(posedge clock) disable iff (reset)
      (accept && s1_wr && s1_col_ff == col_ff) |=> s1_fwd_ff)
      else $error("missed forward of same-entry write");

endmodule
`default_nettype wire

// File: rtl/core/sce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sce_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/sce_grad.sv
// Gradient pipeline: Sobel sums, squares, threshold compare and result register.
`default_nettype none
module sce_grad (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   input  wire sce_pkg::win_job_type job,
   input  wire logic [15:0]          thr_sq,
   output logic                      adv,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sce_pkg::rsp_type          rsp_data
);
   import sce_pkg::*;

   logic             c1_v_ff, c2_v_ff, c3_v_ff, out_v_ff;
   win_job_type      c1_ff;
   logic signed [2:0][10:0] gx_ff, gy_ff, gx_in, gy_in;
   logic [5:0][19:0] sq_ff, sq_in;
   logic [ROW_W-1:0] c2_row_ff, c3_row_ff;
   logic [COL_W-1:0] c2_col_ff, c3_col_ff;
   logic             c2_last_ff, c3_last_ff;
   logic [7:0]       c2_alpha_ff, c3_alpha_ff;
   logic [22:0]      sum_in;
   rsp_type          out_ff, out_in;

   assign adv = !out_v_ff || !rsp_stall;

   always_comb begin
      logic signed [10:0] p [3][3];
      for (int k = 0; k < 3; k++) begin
         for (int dx = 0; dx < 3; dx++) begin
            for (int dy = 0; dy < 3; dy++) begin
               p[dx][dy] = $signed({3'b000, c1_ff.pix[dx][dy][8*k +: 8]});
            end
         end
         gx_in[k] = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) + (p[2][2] - p[0][2]);
         gy_in[k] = (p[0][0] + (p[1][0] <<< 1) + p[2][0])
                  - (p[0][2] + (p[1][2] <<< 1) + p[2][2]);
      end
   end

   // elements of a packed array select as unsigned
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[2*k]   = 20'($signed(gx_ff[k]) * $signed(gx_ff[k]));
         sq_in[2*k+1] = 20'($signed(gy_ff[k]) * $signed(gy_ff[k]));
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 6; i++) begin
         sum_in = sum_in + 23'(sq_ff[i]);
      end
      out_in.out_row         = c3_row_ff;
      out_in.out_col         = c3_col_ff;
      out_in.out_is_edge     = sum_in > {7'd0, thr_sq};
      out_in.out_alpha       = c3_alpha_ff;
      out_in.out_last_of_run = c3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff  <= 1'b0;
         c2_v_ff  <= 1'b0;
         c3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         c1_v_ff  <= job_valid;
         c2_v_ff  <= c1_v_ff;
         c3_v_ff  <= c2_v_ff;
         out_v_ff <= c3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff       <= job;
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         c2_row_ff   <= c1_ff.row;
         c2_col_ff   <= c1_ff.col;
         c2_last_ff  <= c1_ff.last;
         c2_alpha_ff <= c1_ff.pix[1][1][31:24];
         sq_ff       <= sq_in;
         c3_row_ff   <= c2_row_ff;
         c3_col_ff   <= c2_col_ff;
         c3_last_ff  <= c2_last_ff;
         c3_alpha_ff <= c2_alpha_ff;
         out_ff      <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_stall) |=> (out_v_ff && $stable(out_ff)))
      else $error("result changed while stalled");
   a_flow : assert property (@(posedge clock) disable iff (reset)
      (adv && c3_v_ff) |=> out_v_ff)
      else $error("result lost between compare and output");
   a_freeze : assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(c1_v_ff) && $stable(c2_v_ff) && $stable(c3_v_ff)))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// File: test/tb_sobel_color_edge_threshold.sv
// Self-checking testbench for the color Sobel edge threshold block.
`timescale 1ns / 100ps
`default_nettype none
module tb_sobel_color_edge_threshold;
   import sce_pkg::*;

   localparam int PIX_MAX_W  = 4096;
   localparam int CYCLE_MAX  = 400000;
   localparam int DRAIN_WAIT = 20;

   typedef req_type window_type [3][3];   // [column][row: top, middle, bottom]

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [CSR_IW-1:0] csr_index = CSR_WIDTH;
   logic [CSR_W-1:0]  csr_wr_data = '0;

   sobel_color_edge_threshold u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   req_type     older_line [PIX_MAX_W];
   req_type     prev_line  [PIX_MAX_W];
   window_type  win;
   logic [11:0] col_cnt;
   logic [15:0] row_cnt;
   logic [12:0] cfg_width;
   logic [15:0] cfg_height;
   logic [7:0]  cfg_thresh;

   req_type     pixels_pending [$];
   rsp_type     results_expected [$];
   int          cycle_cnt, mismatch_cnt, pixels_sent, results_seen, edges_seen, frames_sent;

   localparam int KX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
   localparam int KY [3][3] = '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}};

   function automatic int chan(req_type p, int k);
      case (k)
         0: chan = p.in_red;
         1: chan = p.in_green;
         default: chan = p.in_blue;
      endcase
   endfunction

   function automatic logic gradient_over(window_type cols, int rm [3], logic [7:0] thr);
      longint acc;
      int gx, gy, v;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
         gx = 0;
         gy = 0;
         for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 3; dx++) begin
               v = chan(cols[dx][rm[dy]], k);
               gx += KX[dy][dx] * v;
               gy += KY[dy][dx] * v;
            end
         acc += gx * gx + gy * gy;
      end
      gradient_over = acc > longint'(thr) * longint'(thr);
   endfunction

   function automatic rsp_type edge_result(window_type cols, int rm [3], int row, int col,
                                           logic [7:0] thr);
      rsp_type r;
      r.out_row         = row[15:0];
      r.out_col         = col[11:0];
      r.out_is_edge     = gradient_over(cols, rm, thr);
      r.out_alpha       = cols[1][rm[1]].in_alpha;
      r.out_last_of_run = 1'b0;
      return r;
   endfunction

   // advance the line stores and window by one pixel, queue the results it releases
   task automatic predict_pixel(req_type pix);
      int w, h, c, r, idx, n;
      int above [3];
      int bottom [3];
      req_type top, mid;
      window_type repl;
      logic row_end, last_row;
      rsp_type res [4];
      above  = '{0, 1, 2};
      bottom = '{1, 2, 2};
      w = (cfg_width == 0) ? 1 : (cfg_width > PIX_MAX_W ? PIX_MAX_W : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      c = col_cnt;
      r = row_cnt;
      idx = c < PIX_MAX_W ? c : PIX_MAX_W - 1;
      if (r == 0) begin
         top = pix;
         mid = pix;
         older_line[idx] = pix;
         prev_line[idx]  = pix;
      end else begin
         top = older_line[idx];
         mid = prev_line[idx];
         older_line[idx] = mid;
         prev_line[idx]  = pix;
      end
      if (c == 0) begin
         for (int j = 0; j < 3; j++) win[j] = '{top, mid, pix};
      end else begin
         win[0] = win[1];
         win[1] = win[2];
         win[2] = '{top, mid, pix};
      end
      repl[0] = win[1];
      repl[1] = win[2];
      repl[2] = win[2];
      row_end  = c >= w - 1;
      last_row = r >= h - 1;
      n = 0;
      if (r >= 1) begin
         if (c >= 1) res[n++] = edge_result(win, above, r - 1, c - 1, cfg_thresh);
         if (row_end) res[n++] = edge_result(repl, above, r - 1, c, cfg_thresh);
      end
      if (last_row) begin
         if (c >= 1) res[n++] = edge_result(win, bottom, r, c - 1, cfg_thresh);
         if (row_end) res[n++] = edge_result(repl, bottom, r, c, cfg_thresh);
      end
      if (n > 0) res[n-1].out_last_of_run = 1'b1;
      for (int i = 0; i < n; i++) results_expected.push_back(res[i]);
      if (row_end) begin
         col_cnt = '0;
         row_cnt = last_row ? 16'd0 : 16'(r + 1);
      end else begin
         col_cnt = 12'(c + 1);
      end
   endtask

   // random idling, none in the first quarter of each window of the cycle counter
   function automatic logic idle_now();
      return (cycle_cnt % 2000) >= 500 && $urandom_range(99) < 15;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cycle_cnt <= 0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         if (cycle_cnt >= CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
         end
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_pixel(req_data);
            pixels_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pixels_pending.size() != 0 && !idle_now()) begin
               req_valid <= 1'b1;
               req_data  <= pixels_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_expected.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected item: row %0d col %0d", rsp_data.out_row,
                           rsp_data.out_col);
            end else begin
               exp_r = results_expected.pop_front();
               if (exp_r.out_is_edge) edges_seen++;
               if (rsp_data !== exp_r) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("mismatch: exp row %0d col %0d edge %0d alpha %0d last %0d, ",
                              exp_r.out_row, exp_r.out_col, exp_r.out_is_edge,
                              exp_r.out_alpha, exp_r.out_last_of_run,
                              "got row %0d col %0d edge %0d alpha %0d last %0d",
                              rsp_data.out_row, rsp_data.out_col, rsp_data.out_is_edge,
                              rsp_data.out_alpha, rsp_data.out_last_of_run);
               end
            end
         end
         rsp_stall <= idle_now();
      end
   end

   task automatic wait_quiet();
      while (pixels_pending.size() != 0 || req_valid || results_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value[CSR_W-1:0];
      case (idx)
         CSR_WIDTH:  cfg_width  = value[12:0];
         CSR_HEIGHT: cfg_height = value[15:0];
         default:    cfg_thresh = value[7:0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_frame(int w, int h, int thr);
      wait_quiet();
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_THRESH, thr);
      frames_sent++;
   endtask

   function automatic req_type px(int r, int g, int b, int a);
      return '{in_red: r[7:0], in_green: g[7:0], in_blue: b[7:0], in_alpha: a[7:0]};
   endfunction

   // style 0: noise, 1: smooth around one color, 2: hard 0/255 channels
   function automatic req_type rand_pixel(int style, req_type base);
      req_type p;
      p = req_type'($urandom);
      if (style == 1) begin
         p.in_red   = base.in_red   ^ 8'($urandom_range(3));
         p.in_green = base.in_green ^ 8'($urandom_range(3));
         p.in_blue  = base.in_blue  ^ 8'($urandom_range(3));
      end else if (style == 2) begin
         p.in_red   = {8{$urandom_range(1) == 1}};
         p.in_green = p.in_red;
         p.in_blue  = {8{$urandom_range(3) == 0}};
      end
      return p;
   endfunction

   initial begin
      int w, h, style;
      req_type base;
      col_cnt = '0;
      row_cnt = '0;
      cfg_width = 13'd1;
      cfg_height = 16'd1;
      cfg_thresh = '0;
      win = '{default: '{default: '0}};
      mismatch_cnt = 0; pixels_sent = 0; results_seen = 0; edges_seen = 0; frames_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero sizes act as one pixel
      set_frame(0, 0, 0);
      pixels_pending.push_back(px(0, 0, 0, 0));
      pixels_pending.push_back(px(255, 255, 255, 255));
      pixels_pending.push_back(px(8'hAA, 8'h55, 8'hAA, 8'h55));

      // 3x3 with a hard vertical edge, strictest threshold
      set_frame(3, 3, 255);
      for (int i = 0; i < 9; i++)
         pixels_pending.push_back((i % 3 == 2) ? px(255, 255, 255, i) : px(0, 0, 0, 255 - i));

      // tallest height, then cut the frame short mid-frame
      set_frame(3, 65535, 40);
      for (int i = 0; i < 6; i++) pixels_pending.push_back(px(i * 40, 255 - i * 40, i, i));
      wait_quiet();
      write_reg(CSR_HEIGHT, 1);
      for (int i = 0; i < 3; i++) pixels_pending.push_back(px(255, 0, 255 * (i & 1), 128));

      // width register above the clamp, then narrowed so the next column ends the row
      set_frame(8191, 1, $urandom_range(255));
      base = req_type'($urandom);
      for (int i = 0; i < 120; i++)
         pixels_pending.push_back(rand_pixel((i / 16) % 3, base));
      wait_quiet();
      write_reg(CSR_WIDTH, 121);
      pixels_pending.push_back(rand_pixel(0, base));

      // random small frames with complete rasters
      while (pixels_sent < 300) begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         set_frame(w, h, $urandom_range(3) == 0 ? 255 * $urandom_range(1) : $urandom_range(255));
         style = $urandom_range(2);
         base = req_type'($urandom);
         for (int i = 0; i < w * h; i++) pixels_pending.push_back(rand_pixel(style, base));
      end
      wait_quiet();

      $display("%0d pixels in %0d frames, %0d results checked (%0d edges)",
               pixels_sent, frames_sent, results_seen, edges_seen);
      $display("sizes from 1x1 to a clamped 121-wide row, thresholds 0..255, %0d mismatches",
               mismatch_cnt);
      if (mismatch_cnt == 0 && results_expected.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sobel_color_edge_threshold.f
rtl/core/sce_pkg.sv
rtl/core/sce_ram.sv
rtl/core/sce_grad.sv
rtl/core/sobel_color_edge_threshold.sv
test/tb_sobel_color_edge_threshold.sv
